// ===== hw/rtl/rtt_pkg.sv =====
// rtt_pkg: shared widths, opcodes and the table entry type for the region table
// translate block; no dependencies

package rtt_pkg;

  // field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned VA_W     = 39;
  localparam int unsigned PA_W     = 56;
  localparam int unsigned LEN_W    = 40;
  localparam int unsigned PAGE_OFF_W = 12;

  // shared adder width covers the widest operand
  localparam int unsigned ALU_W    = PA_W;

  // default table depth
  localparam int unsigned MAX_REGIONS_DEF = 16;

  // operation codes
  localparam logic [OP_W-1:0] OP_CLEAR     = 2'd0;
  localparam logic [OP_W-1:0] OP_MAP       = 2'd1;
  localparam logic [OP_W-1:0] OP_TRANSLATE = 2'd2;

  // one region of the table
  typedef struct packed {
    logic [VA_W-1:0]  virt_base;
    logic [PA_W-1:0]  phys_base;
    logic [LEN_W-1:0] span;
    logic             writable;
  } entry_t;

endpackage

// ===== hw/rtl/rtt_req_if.sv =====
// rtt_req_if: request channel of the region table translate block
// depends on rtt_pkg

interface rtt_req_if import rtt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [VA_W-1:0]  vaddr;
  logic [PA_W-1:0]  paddr;
  logic [LEN_W-1:0] length;
  logic             make_writable;
  logic             write_access;

  modport source (
    output valid, opcode, vaddr, paddr, length, make_writable, write_access,
    input  ready
  );

  modport sink (
    input  valid, opcode, vaddr, paddr, length, make_writable, write_access,
    output ready
  );
endinterface

// ===== hw/rtl/rtt_rsp_if.sv =====
// rtt_rsp_if: response channel of the region table translate block
// depends on rtt_pkg

interface rtt_rsp_if import rtt_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            ok;
  logic [PA_W-1:0] phys_addr;

  modport source (
    output valid, ok, phys_addr,
    input  ready
  );

  modport sink (
    input  valid, ok, phys_addr,
    output ready
  );
endinterface

// ===== hw/rtl/region_table_translate.sv =====
// Region table translate. Holds up to MaxRegions mapped regions (virtual base, physical
// base, page-rounded span, writable flag). Opcode clear empties the table, map appends a
// page-aligned region, translate scans the regions in order and returns the physical
// address of the first region wholly holding the range (a miss if that region is read-only
// and the access a write). One request is worked at a time and req_i.ready is high only
// while the sequencer is idle; a finished response waits in an output register. A single
// shared adder does every subtract, compare and add, and each region costs one table read
// plus up to three adder steps (fewer when an early compare already rules it out); a hit
// takes one more add for the physical address.
// depends on rtt_pkg, rtt_req_if, rtt_rsp_if, rtt_alu, rtt_table

module region_table_translate import rtt_pkg::*; #(
  parameter int unsigned MaxRegions = MAX_REGIONS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rtt_req_if.sink   req_i,
  rtt_rsp_if.source rsp_o
);

  localparam int unsigned IdxW = (MaxRegions > 1) ? $clog2(MaxRegions) : 1;
  localparam int unsigned CntW = $clog2(MaxRegions + 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MROUND = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_SUB1   = 3'd3;
  localparam logic [2:0] ST_SUB2   = 3'd4;
  localparam logic [2:0] ST_CMP    = 3'd5;
  localparam logic [2:0] ST_ADD    = 3'd6;
  localparam logic [2:0] ST_EMIT   = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [VA_W-1:0]  va_q, va_d;
  logic [PA_W-1:0]  pa_q, pa_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic             mkwr_q, mkwr_d;
  logic             wr_q, wr_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [VA_W-1:0]  diff_q, diff_d;
  logic [LEN_W-1:0] rem_q, rem_d;
  logic             rslt_ok_q, rslt_ok_d;
  logic [PA_W-1:0]  rslt_pa_q, rslt_pa_d;
  logic             out_valid_q, out_valid_d;
  logic             out_ok_q, out_ok_d;
  logic [PA_W-1:0]  out_pa_q, out_pa_d;

  logic [LEN_W-1:0] len_eff;
  logic             req_beat;
  logic             map_reject;

  logic [ALU_W-1:0] alu_a, alu_b, alu_sum;
  logic             alu_sub, alu_carry;

  logic             tbl_we, tbl_re;
  entry_t           tbl_wdata, tbl_rdata;

  // shared adder
  rtt_alu u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sub_i   (alu_sub),
    .sum_o   (alu_sum),
    .carry_o (alu_carry)
  );

  // region storage
  rtt_table #(
    .Depth (MaxRegions),
    .IdxW  (IdxW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (cnt_q[IdxW-1:0]),
    .wdata_i (tbl_wdata),
    .re_i    (tbl_re),
    .raddr_i (idx_q[IdxW-1:0]),
    .rdata_o (tbl_rdata)
  );

  assign req_i.ready     = (state_q == ST_IDLE);
  assign req_beat        = req_i.valid & req_i.ready;
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.ok        = out_ok_q;
  assign rsp_o.phys_addr = out_pa_q;

  // zero-length translate counts as one byte
  assign len_eff = (len_q == '0) ? LEN_W'(1) : len_q;

  // adder operand selection per step
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      ST_MROUND: begin
        alu_a = ALU_W'(len_q);
        alu_b = ALU_W'({PAGE_OFF_W{1'b1}});
      end
      ST_SUB1: begin
        alu_a   = ALU_W'(va_q);
        alu_b   = ALU_W'(tbl_rdata.virt_base);
        alu_sub = 1'b1;
      end
      ST_SUB2: begin
        alu_a   = ALU_W'(tbl_rdata.span);
        alu_b   = ALU_W'(len_eff);
        alu_sub = 1'b1;
      end
      ST_CMP: begin
        alu_a   = ALU_W'(rem_q);
        alu_b   = ALU_W'(diff_q);
        alu_sub = 1'b1;
      end
      ST_ADD: begin
        alu_a = ALU_W'(tbl_rdata.phys_base);
        alu_b = ALU_W'(diff_q);
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  // map rejection: misaligned bases, zero size, full table, rounded size overflow
  assign map_reject = (|va_q[PAGE_OFF_W-1:0]) | (|pa_q[PAGE_OFF_W-1:0])
                    | (len_q == '0) | (cnt_q == CntW'(MaxRegions))
                    | alu_sum[LEN_W];

  assign tbl_wdata = '{
    virt_base: va_q,
    phys_base: pa_q,
    span:      {alu_sum[LEN_W-1:PAGE_OFF_W], {PAGE_OFF_W{1'b0}}},
    writable:  mkwr_q
  };

  // sequencer
  always_comb begin
    state_d     = state_q;
    va_d        = va_q;
    pa_d        = pa_q;
    len_d       = len_q;
    mkwr_d      = mkwr_q;
    wr_d        = wr_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    diff_d      = diff_q;
    rem_d       = rem_q;
    rslt_ok_d   = rslt_ok_q;
    rslt_pa_d   = rslt_pa_q;
    out_valid_d = out_valid_q;
    out_ok_d    = out_ok_q;
    out_pa_d    = out_pa_q;
    tbl_we      = 1'b0;
    tbl_re      = 1'b0;

    // response beat taken
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (req_beat) begin
          va_d      = req_i.vaddr;
          pa_d      = req_i.paddr;
          len_d     = req_i.length;
          mkwr_d    = req_i.make_writable;
          wr_d      = req_i.write_access;
          rslt_ok_d = 1'b0;
          rslt_pa_d = '0;
          case (req_i.opcode)
            OP_CLEAR: begin
              cnt_d     = '0;
              rslt_ok_d = 1'b1;
              state_d   = ST_EMIT;
            end
            OP_MAP: begin
              state_d = ST_MROUND;
            end
            OP_TRANSLATE: begin
              idx_d   = '0;
              state_d = ST_READ;
            end
            default: begin
              state_d = ST_EMIT;
            end
          endcase
        end
      end

      ST_MROUND: begin
        if (!map_reject) begin
          tbl_we    = 1'b1;
          cnt_d     = cnt_q + CntW'(1);
          rslt_ok_d = 1'b1;
        end
        state_d = ST_EMIT;
      end

      // fetch the next region or finish with a miss
      ST_READ: begin
        if (idx_q == cnt_q) begin
          state_d = ST_EMIT;
        end else begin
          tbl_re  = 1'b1;
          state_d = ST_SUB1;
        end
      end

      // offset = va - base, borrow means below the region
      ST_SUB1: begin
        if (alu_carry) begin
          diff_d  = alu_sum[VA_W-1:0];
          state_d = ST_SUB2;
        end else begin
          idx_d   = idx_q + CntW'(1);
          state_d = ST_READ;
        end
      end

      // room = span - len, borrow means range longer than region
      ST_SUB2: begin
        if (alu_carry) begin
          rem_d   = alu_sum[LEN_W-1:0];
          state_d = ST_CMP;
        end else begin
          idx_d   = idx_q + CntW'(1);
          state_d = ST_READ;
        end
      end

      // offset must not exceed room
      ST_CMP: begin
        if (!alu_carry) begin
          idx_d   = idx_q + CntW'(1);
          state_d = ST_READ;
        end else if (wr_q && !tbl_rdata.writable) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_ADD;
        end
      end

      // physical base plus offset
      ST_ADD: begin
        rslt_ok_d = 1'b1;
        rslt_pa_d = alu_sum[PA_W-1:0];
        state_d   = ST_EMIT;
      end

      // hand result to the output register once it is free
      ST_EMIT: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_ok_d    = rslt_ok_q;
          out_pa_d    = rslt_pa_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    va_q      <= va_d;
    pa_q      <= pa_d;
    len_q     <= len_d;
    mkwr_q    <= mkwr_d;
    wr_q      <= wr_d;
    idx_q     <= idx_d;
    diff_q    <= diff_d;
    rem_q     <= rem_d;
    rslt_ok_q <= rslt_ok_d;
    rslt_pa_q <= rslt_pa_d;
    out_ok_q  <= out_ok_d;
    out_pa_q  <= out_pa_d;
  end

endmodule

// ===== hw/rtl/rtt_alu.sv =====
// rtt_alu: shared add / subtract unit with carry out, reused for every arithmetic step
// depends on rtt_pkg

module rtt_alu import rtt_pkg::*; (
  input  logic [ALU_W-1:0] a_i,
  input  logic [ALU_W-1:0] b_i,
  input  logic             sub_i,
  output logic [ALU_W-1:0] sum_o,
  output logic             carry_o
);

  // a + b, or a - b as a + ~b + 1; on subtract carry high means no borrow
  assign {carry_o, sum_o} = {1'b0, a_i} + {1'b0, b_i ^ {ALU_W{sub_i}}}
                          + (ALU_W+1)'(sub_i);

endmodule

// ===== hw/rtl/rtt_table.sv =====
// rtt_table: region storage, one write port and one registered read port
// depends on rtt_pkg

module rtt_table import rtt_pkg::*; #(
  parameter int unsigned Depth = MAX_REGIONS_DEF,
  parameter int unsigned IdxW  = 4
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  entry_t          wdata_i,
  input  logic            re_i,
  input  logic [IdxW-1:0] raddr_i,
  output entry_t          rdata_o
);

  entry_t mem_q [Depth];
  entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sim/region_table_translate_tb.sv =====
// region_table_translate_tb: self-checking testbench for the region table translate block
// drives request beats from a directed table and then at random, predicts every response
// depends on rtt_pkg, rtt_req_if, rtt_rsp_if and region_table_translate
`timescale 1ns / 100ps

module region_table_translate_tb;
  import rtt_pkg::*;

  localparam int unsigned RAND_ITEMS     = 430;
  localparam int unsigned QUIET_TAIL     = 60;
  localparam int unsigned DRAIN_CYCLES   = 80;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam logic [63:0] PAGE_MASK      = 64'hFFF;
  localparam logic [63:0] SPAN_LIMIT     = (64'd1 << LEN_W) - 64'd1;
  localparam logic [63:0] LEN_TOP        = 64'd1 << (LEN_W - 1);

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [VA_W-1:0]  vaddr;
    logic [PA_W-1:0]  paddr;
    logic [LEN_W-1:0] length;
    logic             make_writable;
    logic             write_access;
  } req_beat_t;

  typedef struct packed {
    logic            ok;
    logic [PA_W-1:0] phys_addr;
  } rsp_beat_t;

  typedef struct packed {
    req_beat_t req;
    logic      typed;
    rsp_beat_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  rtt_req_if req_if ();
  rtt_rsp_if rsp_if ();

  region_table_translate u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // shadow copy of the region table
  int unsigned      shadow_count = 0;
  logic [VA_W-1:0]  region_virt  [MAX_REGIONS_DEF];
  logic [PA_W-1:0]  region_phys  [MAX_REGIONS_DEF];
  logic [LEN_W-1:0] region_span  [MAX_REGIONS_DEF];
  logic             region_wr    [MAX_REGIONS_DEF];

  rsp_beat_t outcome_q [$];
  dir_row_t  dir_rows [$];

  // tags of the beat on the request bus
  logic      cur_typed;
  rsp_beat_t cur_want;

  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  bit          tail_quiet;
  int unsigned req_idle_pct;
  int unsigned rsp_stall_pct;
  int unsigned map_pct;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // apply one request to the shadow table and return the response it gives
  function automatic rsp_beat_t compute_outcome(req_beat_t b);
    rsp_beat_t   r;
    logic [63:0] span;
    logic [63:0] base;
    logic [63:0] va;
    logic [63:0] len;
    logic [63:0] sum;
    bit          hit;
    r   = '0;
    hit = 1'b0;
    case (b.opcode)
      OP_CLEAR: begin
        shadow_count = 0;
        r.ok = 1'b1;
      end
      OP_MAP: begin
        span = ({24'b0, b.length} + PAGE_MASK) & ~PAGE_MASK;
        if (b.vaddr[PAGE_OFF_W-1:0] == '0 && b.paddr[PAGE_OFF_W-1:0] == '0 &&
            b.length != '0 && shadow_count < MAX_REGIONS_DEF && span <= SPAN_LIMIT) begin
          region_virt[shadow_count] = b.vaddr;
          region_phys[shadow_count] = b.paddr;
          region_span[shadow_count] = span[LEN_W-1:0];
          region_wr[shadow_count]   = b.make_writable;
          shadow_count++;
          r.ok = 1'b1;
        end
      end
      OP_TRANSLATE: begin
        va  = {25'b0, b.vaddr};
        len = (b.length == '0) ? 64'd1 : {24'b0, b.length};
        // first region that holds the whole range decides, read-only stops the scan
        for (int unsigned i = 0; i < shadow_count && !hit; i++) begin
          base = {25'b0, region_virt[i]};
          span = {24'b0, region_span[i]};
          if (va >= base && len <= span && (va - base) <= (span - len)) begin
            hit = 1'b1;
            if (!(b.write_access && !region_wr[i])) begin
              sum         = {8'b0, region_phys[i]} + (va - base);
              r.ok        = 1'b1;
              r.phys_addr = sum[PA_W-1:0];
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic dir_row_t row(logic [OP_W-1:0] op, logic [63:0] va, logic [63:0] pa,
                                   logic [63:0] len, logic mw, logic wa, logic typed,
                                   logic ok, logic [63:0] epa);
    dir_row_t d;
    d.req.opcode        = op;
    d.req.vaddr         = va[VA_W-1:0];
    d.req.paddr         = pa[PA_W-1:0];
    d.req.length        = len[LEN_W-1:0];
    d.req.make_writable = mw;
    d.req.write_access  = wa;
    d.typed             = typed;
    d.want.ok           = ok;
    d.want.phys_addr    = epa[PA_W-1:0];
    return d;
  endfunction

  // random request, mostly maps and translates that land inside mapped regions
  function automatic req_beat_t random_item(int unsigned map_share);
    req_beat_t   b;
    int unsigned pick;
    int unsigned idx;
    logic [63:0] span;
    logic [63:0] off;
    logic [63:0] room;
    logic [63:0] len;
    b.opcode        = OP_TRANSLATE;
    b.vaddr         = VA_W'(rand64());
    b.paddr         = PA_W'(rand64());
    len             = rand64() % (LEN_TOP + 64'd1);
    b.length        = len[LEN_W-1:0];
    b.make_writable = 1'($urandom_range(0, 1));
    b.write_access  = 1'($urandom_range(0, 1));
    pick            = $urandom_range(0, 99);
    if (pick < 3) begin
      b.opcode = OP_CLEAR;
    end else if (pick < 3 + map_share) begin
      // well-formed map, small regions most of the time
      b.opcode = OP_MAP;
      if ($urandom_range(0, 2) == 0) b.vaddr = VA_W'({$urandom_range(0, 63), 12'h000});
      b.vaddr[PAGE_OFF_W-1:0] = '0;
      b.paddr[PAGE_OFF_W-1:0] = '0;
      if ($urandom_range(0, 3) != 0) b.length = LEN_W'($urandom_range(1, 32'h2_0000));
      if (b.length == '0) b.length = LEN_W'(1);
    end else if (pick < 9 + map_share) begin
      // broken map
      b.opcode = OP_MAP;
      b.vaddr[PAGE_OFF_W-1:0] = '0;
      b.paddr[PAGE_OFF_W-1:0] = '0;
      case ($urandom_range(0, 2))
        0: b.vaddr[PAGE_OFF_W-1:0] = PAGE_OFF_W'($urandom_range(1, 4095));
        1: b.paddr[PAGE_OFF_W-1:0] = PAGE_OFF_W'($urandom_range(1, 4095));
        default: b.length = '0;
      endcase
    end else if (pick < 90 && shadow_count > 0) begin
      // translate inside a mapped region, sometimes one byte past its end
      idx  = $urandom_range(0, shadow_count - 1);
      span = {24'b0, region_span[idx]};
      off  = rand64() % span;
      room = span - off;
      if ($urandom_range(0, 3) == 0) len = rand64() % (room + 64'd1);
      else len = 64'($urandom_range(0, 64));
      if (len > room) len = room;
      if ($urandom_range(0, 9) == 0) len = room + 64'd1;
      if (len > LEN_TOP) len = LEN_TOP;
      b.vaddr  = VA_W'({25'b0, region_virt[idx]} + off);
      b.length = len[LEN_W-1:0];
    end
    return b;
  endfunction

  // present one beat, called at a falling edge, returns at the accepting edge
  task automatic send_beat(req_beat_t b, logic typed, rsp_beat_t want);
    if (!tail_quiet && $urandom_range(0, 99) < req_idle_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    req_if.opcode        <= b.opcode;
    req_if.vaddr         <= b.vaddr;
    req_if.paddr         <= b.paddr;
    req_if.length        <= b.length;
    req_if.make_writable <= b.make_writable;
    req_if.write_access  <= b.write_access;
    cur_typed            <= typed;
    cur_want             <= want;
    req_if.valid         <= 1'b1;
    do @(posedge clk); while (!(req_if.valid && req_if.ready));
  endtask

  // predict on accepted request beats, check accepted response beats
  always @(posedge clk) begin
    rsp_beat_t got;
    rsp_beat_t want;
    rsp_beat_t pred;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got.ok        = rsp_if.ok;
      got.phys_addr = rsp_if.phys_addr;
      if (outcome_q.size() == 0) begin
        $error("response beat with no request waiting: ok %0d phys_addr 0x%0h",
               got.ok, got.phys_addr);
        fail_count++;
      end else begin
        want = outcome_q.pop_front();
        if (got.ok !== want.ok) begin
          $error("ok mismatch: expected %0d, actual %0d", want.ok, got.ok);
          fail_count++;
        end
        if (got.phys_addr !== want.phys_addr) begin
          $error("phys_addr mismatch: expected 0x%0h, actual 0x%0h",
                 want.phys_addr, got.phys_addr);
          fail_count++;
        end
      end
    end
    if (rst_n && req_if.valid && req_if.ready) begin
      pred = compute_outcome({req_if.opcode, req_if.vaddr, req_if.paddr,
                              req_if.length, req_if.make_writable,
                              req_if.write_access});
      outcome_q.push_back(cur_typed ? cur_want : pred);
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // response side back-pressure in bursts
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!tail_quiet && $urandom_range(0, 99) < rsp_stall_pct) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      rsp_if.ready <= 1'b1;
    end
  end

  // reset, directed table, random phases, drain
  initial begin
    rst_n                = 1'b0;
    req_if.valid         = 1'b0;
    req_if.opcode        = OP_CLEAR;
    req_if.vaddr         = '0;
    req_if.paddr         = '0;
    req_if.length        = '0;
    req_if.make_writable = 1'b0;
    req_if.write_access  = 1'b0;
    cur_typed            = 1'b0;
    cur_want             = '0;
    tail_quiet           = 1'b0;
    req_idle_pct         = 20;
    rsp_stall_pct        = 10;
    map_pct              = 30;

    dir_rows = {
      // empty table misses, then map one page at 0x1000
      row(OP_TRANSLATE, 64'h0, 64'h0, 64'h0, 1'b0, 1'b0, 1'b1, 1'b0, 64'h0),
      row(OP_MAP, 64'h1000, 64'h0, 64'h1, 1'b0, 1'b0, 1'b1, 1'b1, 64'h0),
      // rejected maps: unaligned virtual, unaligned physical, zero size; then a map of the top virtual page
      row(OP_MAP, 64'h1001, 64'h2000, 64'h1000, 1'b1, 1'b0, 1'b1, 1'b0, 64'h0),
      row(OP_MAP, 64'h2000, 64'hFF_FFFF_FFFF_FFFF, 64'h1000, 1'b1, 1'b0, 1'b1, 1'b0, 64'h0),
      row(OP_MAP, 64'h3000, 64'h3000, 64'h0, 1'b1, 1'b1, 1'b1, 1'b0, 64'h0),
      row(OP_MAP, 64'h7F_FFFF_F000, 64'hFF_FFFF_FFFF_F000, 64'h1000, 1'b1, 1'b0,
          1'b1, 1'b1, 64'h0),
      // zero length counts as one byte, physical address zero is a hit
      row(OP_TRANSLATE, 64'h1000, 64'h0, 64'h0, 1'b0, 1'b0, 1'b1, 1'b1, 64'h0),
      row(OP_TRANSLATE, 64'h1FFF, 64'h0, 64'h1, 1'b0, 1'b0, 1'b0, 1'b0, 64'h0),
      row(OP_TRANSLATE, 64'h1FFF, 64'h0, 64'h2, 1'b0, 1'b0, 1'b1, 1'b0, 64'h0),
      // write to a read-only region fails, to the writable top page hits; clear then empties the table
      row(OP_TRANSLATE, 64'h1000, 64'h0, 64'h1000, 1'b0, 1'b1, 1'b1, 1'b0, 64'h0),
      row(OP_TRANSLATE, 64'h7F_FFFF_FFFF, 64'h0, 64'h1, 1'b0, 1'b1, 1'b1, 1'b1,
          64'hFF_FFFF_FFFF_FFFF),
      row(OP_CLEAR, 64'h0, 64'h0, 64'h0, 1'b0, 1'b0, 1'b1, 1'b1, 64'h0),
      row(OP_TRANSLATE, 64'h1000, 64'h0, 64'h1, 1'b0, 1'b0, 1'b1, 1'b0, 64'h0),
      // largest region, then an overlapping one that never wins
      row(OP_MAP, 64'h0, 64'h1234_5000, 64'h80_0000_0000, 1'b1, 1'b0, 1'b1, 1'b1, 64'h0),
      row(OP_MAP, 64'h0, 64'hFF_FFFF_FFFF_F000, 64'h55_5555_5555, 1'b0, 1'b1,
          1'b1, 1'b1, 64'h0),
      row(OP_TRANSLATE, 64'h7F_FFFF_FFFF, 64'h0, 64'h1, 1'b0, 1'b1, 1'b0, 1'b0, 64'h0),
      row(OP_TRANSLATE, 64'h0, 64'h0, 64'h80_0000_0000, 1'b0, 1'b0, 1'b1, 1'b1,
          64'h1234_5000),
      row(OP_CLEAR, 64'h0, 64'h0, 64'h0, 1'b0, 1'b0, 1'b1, 1'b1, 64'h0),
      // physical sum wraps at the top of the address space
      row(OP_MAP, 64'h0, 64'hFF_FFFF_FFFF_F000, 64'h2A_AAAA_AAAA, 1'b0, 1'b0,
          1'b1, 1'b1, 64'h0),
      row(OP_TRANSLATE, 64'h2000, 64'h0, 64'h10, 1'b0, 1'b0, 1'b0, 1'b0, 64'h0),
      // read-only first match stops the scan before a writable one
      row(OP_MAP, 64'h0, 64'h5000, 64'h1_0000, 1'b1, 1'b0, 1'b1, 1'b1, 64'h0),
      row(OP_TRANSLATE, 64'h3000, 64'h0, 64'h4, 1'b0, 1'b1, 1'b1, 1'b0, 64'h0),
      row(OP_TRANSLATE, 64'h3000, 64'h0, 64'h4, 1'b0, 1'b0, 1'b0, 1'b0, 64'h0),
      row(OP_TRANSLATE, 64'h2A_AAAA_B000, 64'h0, 64'h1, 1'b0, 1'b0, 1'b1, 1'b0, 64'h0)
    };

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      @(negedge clk);
      send_beat(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
      req_beat_t b;
      // new idling and traffic mix every few dozen beats
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: req_idle_pct = 0;
          1: req_idle_pct = 8;
          default: req_idle_pct = 25;
        endcase
        case ($urandom_range(0, 2))
          0: rsp_stall_pct = 0;
          1: rsp_stall_pct = 5;
          default: rsp_stall_pct = 15;
        endcase
        map_pct = ($urandom_range(0, 2) == 0) ? 60 : 30;
      end
      tail_quiet = (n >= RAND_ITEMS - QUIET_TAIL);
      @(negedge clk);
      b = random_item(map_pct);
      send_beat(b, 1'b0, '0);
    end

    @(negedge clk);
    req_if.valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && outcome_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/rtt_pkg.sv
hw/rtl/rtt_req_if.sv
hw/rtl/rtt_rsp_if.sv
hw/rtl/rtt_alu.sv
hw/rtl/rtt_table.sv
hw/rtl/region_table_translate.sv
sim/region_table_translate_tb.sv
